>>> sv/s2d_pkg.sv
package s2d_pkg;

  // Register map, one 32-bit word per register
  localparam int unsigned NUM_REGS       = 5;
  localparam int unsigned REG_IDX_BITS   = 3;
  localparam int unsigned APB_ADDR_BITS  = 5;
  localparam int unsigned APB_DATA_BITS  = 32;

  localparam logic [REG_IDX_BITS-1:0] REG_BATCH    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_CHANNELS = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_BLOCK    = 3'd4;

  localparam int unsigned BATCH_REG_BITS = 7;
  localparam int unsigned DIM_REG_BITS   = 13;
  localparam int unsigned BLOCK_REG_BITS = 5;

  localparam int unsigned MAX_BATCH      = 64;
  localparam int unsigned MAX_BLOCK      = 16;
  localparam int unsigned BATCH_IDX_BITS = 6;
  localparam int unsigned REM_BITS       = 4;
  localparam int unsigned SQ_BITS        = 9;
  localparam int unsigned RBASE_BITS     = 8;

  typedef struct packed {
    logic busy;
    logic clear;
  } cfg_stat_t;

endpackage

>>> sv/s2d_cfg.sv
module s2d_cfg #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [s2d_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [s2d_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [s2d_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  output s2d_pkg::cfg_stat_t                   stat_o,
  output logic [s2d_pkg::BATCH_REG_BITS-1:0]   nb_o,
  output logic [DIM_BITS:0]                    hh_o,
  output logic [DIM_BITS:0]                    ww_o,
  output logic [DIM_BITS:0]                    cc_o,
  output logic [s2d_pkg::BLOCK_REG_BITS-1:0]   s_o,
  output logic [s2d_pkg::SQ_BITS-1:0]          ss_o,
  output logic [DIM_BITS:0]                    oh_o,
  output logic [DIM_BITS:0]                    ow_o,
  output logic [DIM_BITS+8:0]                  oc_o
);
  import s2d_pkg::*;

  localparam int unsigned DW      = DIM_BITS + 1;
  localparam int unsigned OCW     = DW + 8;
  localparam int unsigned CW      = $clog2(DW);
  localparam int unsigned DIM_MAX = 1 << DIM_BITS;

  typedef enum logic [4:0] {
    CFG_IDLE   = 5'b00001,
    CFG_LOAD   = 5'b00010,
    CFG_SQUARE = 5'b00100,
    CFG_DIV_H  = 5'b01000,
    CFG_DIV_W  = 5'b10000
  } cfg_state_e;

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_BITS-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > 32'(DIM_MAX)) begin
      r = DW'(DIM_MAX);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic [BATCH_REG_BITS-1:0] batch_q;
  logic [DIM_REG_BITS-1:0]   height_q, width_q, chan_q;
  logic [BLOCK_REG_BITS-1:0] block_q;

  logic [REG_IDX_BITS-1:0]   idx;
  logic                      wr_en, hit;

  cfg_state_e                state_q;
  logic [BATCH_REG_BITS-1:0] nb_q, nb_eff;
  logic [DW-1:0]             hh_q, ww_q, cc_q, oh_q, ow_q;
  logic [BLOCK_REG_BITS-1:0] s_q, s_eff;
  logic [SQ_BITS-1:0]        ss_q;
  logic [OCW-1:0]            oc_q;

  logic [DW-1:0]             dvd_q, dvd_d;
  logic [REM_BITS-1:0]       rem_q, rem_d;
  logic [CW-1:0]             cnt_q;
  logic [REM_BITS:0]         trial;
  logic                      take, div_done;

  assign idx    = paddr[APB_ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign hit    = idx < REG_IDX_BITS'(NUM_REGS);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q  <= BATCH_REG_BITS'(1);
      height_q <= DIM_REG_BITS'(1);
      width_q  <= DIM_REG_BITS'(1);
      chan_q   <= DIM_REG_BITS'(1);
      block_q  <= BLOCK_REG_BITS'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_BATCH:    batch_q  <= pwdata[BATCH_REG_BITS-1:0];
        REG_HEIGHT:   height_q <= pwdata[DIM_REG_BITS-1:0];
        REG_WIDTH:    width_q  <= pwdata[DIM_REG_BITS-1:0];
        REG_CHANNELS: chan_q   <= pwdata[DIM_REG_BITS-1:0];
        REG_BLOCK:    block_q  <= pwdata[BLOCK_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BATCH:    prdata = APB_DATA_BITS'(batch_q);
      REG_HEIGHT:   prdata = APB_DATA_BITS'(height_q);
      REG_WIDTH:    prdata = APB_DATA_BITS'(width_q);
      REG_CHANNELS: prdata = APB_DATA_BITS'(chan_q);
      REG_BLOCK:    prdata = APB_DATA_BITS'(block_q);
      default:      prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the range saturates
  always_comb begin
    if (batch_q == '0) begin
      nb_eff = BATCH_REG_BITS'(1);
    end else if (batch_q > BATCH_REG_BITS'(MAX_BATCH)) begin
      nb_eff = BATCH_REG_BITS'(MAX_BATCH);
    end else begin
      nb_eff = batch_q;
    end
    if (block_q == '0) begin
      s_eff = BLOCK_REG_BITS'(1);
    end else if (block_q > BLOCK_REG_BITS'(MAX_BLOCK)) begin
      s_eff = BLOCK_REG_BITS'(MAX_BLOCK);
    end else begin
      s_eff = block_q;
    end
  end

  // Restoring divide by S, one quotient bit per cycle
  assign trial    = {rem_q, dvd_q[DW-1]};
  assign take     = trial >= (REM_BITS+1)'(s_q);
  assign rem_d    = take ? REM_BITS'(trial - (REM_BITS+1)'(s_q)) : REM_BITS'(trial);
  assign dvd_d    = {dvd_q[DW-2:0], take};
  assign div_done = cnt_q == CW'(DW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CFG_IDLE;
      nb_q    <= BATCH_REG_BITS'(1);
      hh_q    <= DW'(1);
      ww_q    <= DW'(1);
      cc_q    <= DW'(1);
      s_q     <= BLOCK_REG_BITS'(1);
      ss_q    <= SQ_BITS'(1);
      oc_q    <= OCW'(1);
      oh_q    <= DW'(1);
      ow_q    <= DW'(1);
      dvd_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (wr_en && hit) begin
      state_q <= CFG_LOAD;
    end else begin
      unique case (state_q)
        CFG_IDLE: ;
        CFG_LOAD: begin
          nb_q    <= nb_eff;
          hh_q    <= clamp_dim(height_q);
          ww_q    <= clamp_dim(width_q);
          cc_q    <= clamp_dim(chan_q);
          s_q     <= s_eff;
          ss_q    <= SQ_BITS'(s_eff) * SQ_BITS'(s_eff);
          dvd_q   <= clamp_dim(height_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= CFG_SQUARE;
        end
        CFG_SQUARE: begin
          oc_q    <= OCW'(cc_q) * OCW'(ss_q);
          state_q <= CFG_DIV_H;
        end
        CFG_DIV_H: begin
          if (div_done) begin
            oh_q    <= dvd_d;
            dvd_q   <= ww_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= CFG_DIV_W;
          end else begin
            rem_q <= rem_d;
            cnt_q <= cnt_q + CW'(1);
            dvd_q <= dvd_d;
          end
        end
        CFG_DIV_W: begin
          if (div_done) begin
            ow_q    <= dvd_d;
            state_q <= CFG_IDLE;
          end else begin
            rem_q <= rem_d;
            cnt_q <= cnt_q + CW'(1);
            dvd_q <= dvd_d;
          end
        end
        default: state_q <= CFG_IDLE;
      endcase
    end
  end

  assign stat_o.busy  = state_q != CFG_IDLE;
  assign stat_o.clear = wr_en && hit;

  assign nb_o = nb_q;
  assign hh_o = hh_q;
  assign ww_o = ww_q;
  assign cc_o = cc_q;
  assign s_o  = s_q;
  assign ss_o = ss_q;
  assign oh_o = oh_q;
  assign ow_o = ow_q;
  assign oc_o = oc_q;

endmodule

>>> sv/s2d_front.sv
module s2d_front #(
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned DIM_BITS  = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  s2d_pkg::cfg_stat_t                   stat_i,
  input  logic                                 push_i,
  input  logic [DATA_BITS-1:0]                 value_i,
  input  logic [s2d_pkg::BATCH_REG_BITS-1:0]   nb_i,
  input  logic [DIM_BITS:0]                    hh_i,
  input  logic [DIM_BITS:0]                    ww_i,
  input  logic [DIM_BITS:0]                    cc_i,
  input  logic [s2d_pkg::BLOCK_REG_BITS-1:0]   s_i,
  input  logic [s2d_pkg::SQ_BITS-1:0]          ss_i,
  output logic [DATA_BITS+s2d_pkg::BATCH_IDX_BITS+3*DIM_BITS+10:0] desc_o
);
  import s2d_pkg::*;

  localparam int unsigned DW  = DIM_BITS + 1;
  localparam int unsigned EW  = DW + 1;
  localparam int unsigned OCW = DW + 8;
  localparam int unsigned CBW = DIM_BITS + 8;

  logic [BATCH_IDX_BITS-1:0] bat_q;
  logic [DIM_BITS-1:0]       row_q, col_q, chn_q, rblk_q, cblk_q;
  logic [REM_BITS-1:0]       rrem_q, crem_q;
  logic [CBW-1:0]            cbase_q;
  logic [RBASE_BITS-1:0]     rbase_q;

  logic last_c, last_w, last_h, last_n, last;
  logic rwrap, cwrap, in_blk;
  logic [OCW-1:0] choff;

  assign last_c = (DW'(chn_q) + DW'(1)) >= cc_i;
  assign last_w = (DW'(col_q) + DW'(1)) >= ww_i;
  assign last_h = (DW'(row_q) + DW'(1)) >= hh_i;
  assign last_n = (BATCH_REG_BITS'(bat_q) + BATCH_REG_BITS'(1)) >= nb_i;
  assign last   = last_c && last_w && last_h && last_n;

  assign rwrap = (BLOCK_REG_BITS'(rrem_q) + BLOCK_REG_BITS'(1)) >= s_i;
  assign cwrap = (BLOCK_REG_BITS'(crem_q) + BLOCK_REG_BITS'(1)) >= s_i;

  // A row or column is covered when its whole block fits inside the image
  assign in_blk = (EW'(row_q) - EW'(rrem_q) + EW'(s_i) <= EW'(hh_i)) &&
                  (EW'(col_q) - EW'(crem_q) + EW'(s_i) <= EW'(ww_i));

  assign choff = OCW'(cbase_q) + OCW'(rbase_q) + OCW'(crem_q);

  assign desc_o = {value_i, bat_q, rblk_q, cblk_q, choff, in_blk, last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bat_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      chn_q   <= '0;
      rrem_q  <= '0;
      crem_q  <= '0;
      rblk_q  <= '0;
      cblk_q  <= '0;
      cbase_q <= '0;
      rbase_q <= '0;
    end else if (stat_i.clear) begin
      bat_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      chn_q   <= '0;
      rrem_q  <= '0;
      crem_q  <= '0;
      rblk_q  <= '0;
      cblk_q  <= '0;
      cbase_q <= '0;
      rbase_q <= '0;
    end else if (push_i) begin
      if (!last_c) begin
        chn_q   <= chn_q + DIM_BITS'(1);
        cbase_q <= cbase_q + CBW'(ss_i);
      end else begin
        chn_q   <= '0;
        cbase_q <= '0;
        if (!last_w) begin
          col_q <= col_q + DIM_BITS'(1);
          if (cwrap) begin
            crem_q <= '0;
            cblk_q <= cblk_q + DIM_BITS'(1);
          end else begin
            crem_q <= crem_q + REM_BITS'(1);
          end
        end else begin
          col_q  <= '0;
          crem_q <= '0;
          cblk_q <= '0;
          if (!last_h) begin
            row_q <= row_q + DIM_BITS'(1);
            if (rwrap) begin
              rrem_q  <= '0;
              rblk_q  <= rblk_q + DIM_BITS'(1);
              rbase_q <= '0;
            end else begin
              rrem_q  <= rrem_q + REM_BITS'(1);
              rbase_q <= rbase_q + RBASE_BITS'(s_i);
            end
          end else begin
            row_q   <= '0;
            rrem_q  <= '0;
            rblk_q  <= '0;
            rbase_q <= '0;
            bat_q   <= last_n ? '0 : bat_q + BATCH_IDX_BITS'(1);
          end
        end
      end
    end
  end

  a_wrap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && last |=> (bat_q == '0 && row_q == '0 && col_q == '0 && chn_q == '0))
    else $error("counters did not wrap after the final word");

  a_rem_below_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    BLOCK_REG_BITS'(rrem_q) < s_i && BLOCK_REG_BITS'(crem_q) < s_i)
    else $error("block remainder reached block size");

endmodule

>>> sv/s2d_fifo.sv
module s2d_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue holds more words than its depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

>>> sv/s2d_back.sv
module s2d_back #(
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned DIM_BITS  = 12,
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [DATA_BITS+s2d_pkg::BATCH_IDX_BITS+3*DIM_BITS+10:0] desc_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  input  logic [DIM_BITS:0]      oh_i,
  input  logic [DIM_BITS:0]      ow_i,
  input  logic [DIM_BITS+8:0]    oc_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DATA_BITS-1:0]   out_value_o,
  output logic [ADDR_BITS-1:0]   out_address_o,
  output logic                   in_range_o,
  output logic                   last_element_o
);
  import s2d_pkg::*;

  localparam int unsigned DW  = DIM_BITS + 1;
  localparam int unsigned OCW = DW + 8;
  localparam int unsigned PW  = ADDR_BITS + OCW;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ROW  = 4'b0010,
    B_COL  = 4'b0100,
    B_CHAN = 4'b1000
  } back_state_e;

  logic [DATA_BITS-1:0]      d_value;
  logic [BATCH_IDX_BITS-1:0] d_bat;
  logic [DIM_BITS-1:0]       d_rblk, d_cblk;
  logic [OCW-1:0]            d_choff;
  logic                      d_inside, d_last;

  back_state_e               st_q;
  logic [DATA_BITS-1:0]      h_value_q;
  logic [BATCH_IDX_BITS-1:0] h_bat_q;
  logic [DIM_BITS-1:0]       h_rblk_q, h_cblk_q;
  logic [OCW-1:0]            h_choff_q;
  logic                      h_inside_q, h_last_q;
  logic [ADDR_BITS-1:0]      acc_q;

  logic [ADDR_BITS-1:0]      mul_a, mul_add, mul_res;
  logic [OCW-1:0]            mul_b;
  logic [PW-1:0]             prod;
  logic                      fire, load;

  logic                      out_valid_q, out_range_q, out_last_q;
  logic [DATA_BITS-1:0]      out_value_q;
  logic [ADDR_BITS-1:0]      out_addr_q;

  assign {d_value, d_bat, d_rblk, d_cblk, d_choff, d_inside, d_last} = desc_i;

  // Finish the current word only when the output stage can take it
  assign fire  = (st_q == B_CHAN) && (!out_valid_q || out_ready_i);
  assign load  = ((st_q == B_IDLE) || fire) && !empty_i;
  assign pop_o = load;

  // Shared multiply-add: ((n*oh + hb)*ow + wb)*oc + channel offset
  always_comb begin
    unique case (st_q)
      B_ROW: begin
        mul_a   = ADDR_BITS'(h_bat_q);
        mul_b   = OCW'(oh_i);
        mul_add = ADDR_BITS'(h_rblk_q);
      end
      B_COL: begin
        mul_a   = acc_q;
        mul_b   = OCW'(ow_i);
        mul_add = ADDR_BITS'(h_cblk_q);
      end
      B_CHAN: begin
        mul_a   = acc_q;
        mul_b   = oc_i;
        mul_add = ADDR_BITS'(h_choff_q);
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_add = '0;
      end
    endcase
  end

  assign prod    = PW'(mul_a) * PW'(mul_b);
  assign mul_res = prod[ADDR_BITS-1:0] + mul_add;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
    end else begin
      unique case (st_q)
        B_IDLE: if (load) begin
          st_q <= B_ROW;
        end
        B_ROW:  st_q <= B_COL;
        B_COL:  st_q <= B_CHAN;
        B_CHAN: if (fire) begin
          st_q <= load ? B_ROW : B_IDLE;
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      h_value_q  <= d_value;
      h_bat_q    <= d_bat;
      h_rblk_q   <= d_rblk;
      h_cblk_q   <= d_cblk;
      h_choff_q  <= d_choff;
      h_inside_q <= d_inside;
      h_last_q   <= d_last;
    end
    if (st_q == B_ROW || st_q == B_COL) begin
      acc_q <= mul_res;
    end
    if (fire) begin
      out_value_q <= h_value_q;
      out_addr_q  <= h_inside_q ? mul_res : '0;
      out_range_q <= h_inside_q;
      out_last_q  <= h_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_address_o  = out_addr_q;
  assign in_range_o     = out_range_q;
  assign last_element_o = out_last_q;

  a_outside_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_range_q |-> out_addr_q == '0)
    else $error("out of range word carries a nonzero address");

endmodule

>>> sv/space_to_depth_address_gen_core.sv
// An accepted input word waits in the queue, then the back end's single multiply-add unit steps
// through row, column and channel products for it before the result reaches the output register;
// the back end takes the next word from the queue only as it finishes the current one.
// After each write to a mapped register the input is held off
// while H/S and W/S are divided one bit per cycle.
// Reset: registers read 1, position counters clear, input ready at once.
module space_to_depth_address_gen_core #(
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned DIM_BITS  = 12,
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [s2d_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [s2d_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [s2d_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [DATA_BITS-1:0]              element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [DATA_BITS-1:0]              out_value_o,
  output logic [ADDR_BITS-1:0]              out_address_o,
  output logic                              in_range_o,
  output logic                              last_element_o
);
  import s2d_pkg::*;

  localparam int unsigned DESC_W = DATA_BITS + BATCH_IDX_BITS + 3 * DIM_BITS + 11;

  cfg_stat_t                 stat;
  logic [BATCH_REG_BITS-1:0] nb;
  logic [DIM_BITS:0]         hh, ww, cc, oh, ow;
  logic [BLOCK_REG_BITS-1:0] s;
  logic [SQ_BITS-1:0]        ss;
  logic [DIM_BITS+8:0]       oc;

  logic [DESC_W-1:0]         desc_in, desc_out;
  logic                      push, pop, full, empty;

  assign in_ready_o = !stat.busy && !full;
  assign push       = in_valid_i && in_ready_o;

  s2d_cfg #(
    .DIM_BITS (DIM_BITS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stat_o  (stat),
    .nb_o    (nb),
    .hh_o    (hh),
    .ww_o    (ww),
    .cc_o    (cc),
    .s_o     (s),
    .ss_o    (ss),
    .oh_o    (oh),
    .ow_o    (ow),
    .oc_o    (oc)
  );

  s2d_front #(
    .DATA_BITS (DATA_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .push_i  (push),
    .value_i (element_value_i),
    .nb_i    (nb),
    .hh_i    (hh),
    .ww_i    (ww),
    .cc_i    (cc),
    .s_i     (s),
    .ss_i    (ss),
    .desc_o  (desc_in)
  );

  s2d_fifo #(
    .WIDTH (DESC_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_in),
    .pop_i   (pop),
    .data_o  (desc_out),
    .full_o  (full),
    .empty_o (empty)
  );

  s2d_back #(
    .DATA_BITS (DATA_BITS),
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_i         (desc_out),
    .empty_i        (empty),
    .pop_o          (pop),
    .oh_i           (oh),
    .ow_i           (ow),
    .oc_i           (oc),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .out_address_o  (out_address_o),
    .in_range_o     (in_range_o),
    .last_element_o (last_element_o)
  );

endmodule

>>> tb/sv/space_to_depth_address_gen_core_tb.sv
`timescale 1ns / 100ps

module space_to_depth_address_gen_core_tb;
  import s2d_pkg::*;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned DIM_W        = 12;
  localparam int unsigned ADDR_W       = 24;
  localparam longint unsigned DIM_MAX  = longint'(1) << DIM_W;
  localparam logic [REG_IDX_BITS-1:0] REG_IDX_MAX = REG_IDX_BITS'((1 << REG_IDX_BITS) - 1);
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_SLACK  = 6;
  localparam int unsigned MAX_REPORTS  = 200;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [ADDR_W-1:0] address;
    logic              in_range;
    logic              last;
  } s2d_word_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [DATA_W-1:0]        element_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [DATA_W-1:0]        out_value_o;
  logic [ADDR_W-1:0]        out_address_o;
  logic                     in_range_o;
  logic                     last_element_o;

  space_to_depth_address_gen_core #(
    .DATA_BITS(DATA_W),
    .DIM_BITS (DIM_W),
    .ADDR_BITS(ADDR_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .out_address_o  (out_address_o),
    .in_range_o     (in_range_o),
    .last_element_o (last_element_o)
  );

  // Pending input words and predicted output words
  logic [DATA_W-1:0] word_q[$];
  s2d_word_t         result_q[$];

  // Predictor copy of the register file and position counters
  logic [APB_DATA_BITS-1:0] cfg_reg[NUM_REGS];
  longint unsigned pos_batch, pos_row, pos_col, pos_chan, rem_row, rem_col;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned n_checked, n_inside, n_last, n_writes;
  bit          in_fire;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned eff_dim(input logic [APB_DATA_BITS-1:0] v,
                                              input longint unsigned top);
    if (v == '0) return 1;
    return (v > top) ? top : longint'(v);
  endfunction

  function automatic logic [APB_DATA_BITS-1:0] field_mask(input logic [REG_IDX_BITS-1:0] idx);
    case (idx)
      REG_BATCH:                         return (1 << BATCH_REG_BITS) - 1;
      REG_HEIGHT, REG_WIDTH, REG_CHANNELS: return (1 << DIM_REG_BITS) - 1;
      REG_BLOCK:                         return (1 << BLOCK_REG_BITS) - 1;
      default:                           return '0;
    endcase
  endfunction

  function automatic void clear_position();
    pos_batch = 0;
    pos_row   = 0;
    pos_col   = 0;
    pos_chan  = 0;
    rem_row   = 0;
    rem_col   = 0;
  endfunction

  // Compute the destination of one element and advance the NHWC position
  function automatic void predict_s2d(input logic [DATA_W-1:0] v);
    longint unsigned nb, hh, ww, cc, s, oh, ow, oc, addr;
    bit in_blk, lc, lw, lh, ln;
    s2d_word_t w;
    nb = eff_dim(cfg_reg[REG_BATCH], MAX_BATCH);
    hh = eff_dim(cfg_reg[REG_HEIGHT], DIM_MAX);
    ww = eff_dim(cfg_reg[REG_WIDTH], DIM_MAX);
    cc = eff_dim(cfg_reg[REG_CHANNELS], DIM_MAX);
    s  = eff_dim(cfg_reg[REG_BLOCK], MAX_BLOCK);
    oh = hh / s;
    ow = ww / s;
    oc = cc * s * s;
    in_blk = (pos_row < oh * s) && (pos_col < ow * s);
    lc = (pos_chan + 1 >= cc);
    lw = (pos_col + 1 >= ww);
    lh = (pos_row + 1 >= hh);
    ln = (pos_batch + 1 >= nb);
    addr = 0;
    if (in_blk)
      addr = ((pos_batch * oh + pos_row / s) * ow + pos_col / s) * oc
           + pos_chan * s * s + rem_row * s + rem_col;
    w.value    = v;
    w.address  = addr[ADDR_W-1:0];
    w.in_range = in_blk;
    w.last     = lc && lw && lh && ln;
    result_q.push_back(w);

    if (!lc) begin
      pos_chan++;
    end else begin
      pos_chan = 0;
      if (!lw) begin
        pos_col++;
        rem_col = (rem_col + 1 >= s) ? 0 : rem_col + 1;
      end else begin
        pos_col = 0;
        rem_col = 0;
        if (!lh) begin
          pos_row++;
          rem_row = (rem_row + 1 >= s) ? 0 : rem_row + 1;
        end else begin
          pos_row   = 0;
          rem_row   = 0;
          pos_batch = ln ? 0 : pos_batch + 1;
        end
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  // Input side: hold a word until taken, otherwise offer the next one or idle at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fire) begin
      in_valid_i <= 1'b1;
    end else if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid_i      <= 1'b1;
      element_value_i <= word_q.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else         out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : mon
    s2d_word_t want;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) predict_s2d(element_value_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected output word, expected none, actual value %h address %h",
                   $realtime, out_value_o, out_address_o);
      end else begin
        want = result_q.pop_front();
        n_checked++;
        if (want.in_range) n_inside++;
        if (want.last) n_last++;
        check_field("out_value", want.value, out_value_o);
        check_field("out_address", want.address, out_address_o);
        check_field("in_range", want.in_range, in_range_o);
        check_field("last_element", want.last, last_element_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, result_q.size());
      $display("space_to_depth_address_gen_core_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [APB_DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
    // Unmapped indexes leave the counters alone
    if (idx < NUM_REGS) begin
      cfg_reg[idx] = value & field_mask(idx);
      clear_position();
    end
  endtask

  task automatic write_shape(input logic [APB_DATA_BITS-1:0] nb, input logic [APB_DATA_BITS-1:0] hh,
                             input logic [APB_DATA_BITS-1:0] ww, input logic [APB_DATA_BITS-1:0] cc,
                             input logic [APB_DATA_BITS-1:0] s);
    write_reg(REG_BATCH, nb);
    write_reg(REG_HEIGHT, hh);
    write_reg(REG_WIDTH, ww);
    write_reg(REG_CHANNELS, cc);
    write_reg(REG_BLOCK, s);
  endtask

  // Mostly small shapes so tensors wrap often, with zero, oversize and max mixed in
  function automatic logic [APB_DATA_BITS-1:0] pick_cfg_value(input logic [REG_IDX_BITS-1:0] idx);
    int unsigned r;
    r = $urandom_range(11);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    case (idx)
      REG_BATCH:    return (r == 2) ? MAX_BATCH : $urandom_range(3, 1);
      REG_CHANNELS: return (r == 2) ? DIM_MAX : $urandom_range(4, 1);
      REG_BLOCK:    return (r == 2) ? MAX_BLOCK : $urandom_range(5, 1);
      default:      return (r == 2) ? DIM_MAX : $urandom_range(9, 1);
    endcase
  endfunction

  task automatic push_words(input int unsigned n);
    repeat (n) word_q.push_back($urandom);
  endtask

  // Look after the falling edge has settled so a word offered on it is seen
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (word_q.size() != 0 || in_valid_i || result_q.size() != 0);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_items);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned act;
    logic [REG_IDX_BITS-1:0] idx;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      act = $urandom_range(9);
      if (act < 6) begin
        write_shape(pick_cfg_value(REG_BATCH), pick_cfg_value(REG_HEIGHT),
                    pick_cfg_value(REG_WIDTH), pick_cfg_value(REG_CHANNELS),
                    pick_cfg_value(REG_BLOCK));
      end else if (act < 8) begin
        idx = REG_IDX_BITS'($urandom_range(NUM_REGS - 1));
        write_reg(idx, pick_cfg_value(idx));
      end else if (act == 8) begin
        idx = REG_IDX_BITS'($urandom_range(REG_IDX_MAX, NUM_REGS));
        write_reg(idx, $urandom);
      end
      // Otherwise continue the current tensor across the pause
      seg_len = $urandom_range(70, 10);
      push_words(seg_len);
      sent += seg_len;
      wait_drained();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    element_value_i = '0;
    out_ready_i     = 1'b0;
    send_idle_pct   = 10;
    recv_stall_pct  = 68;
    err_cnt         = 0;
    cycle_cnt       = 0;
    n_checked       = 0;
    n_inside        = 0;
    n_last          = 0;
    n_writes        = 0;
    in_fire         = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) cfg_reg[i] = 1;
    clear_position();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset shape: every word is a whole tensor
    word_q.push_back('0);
    word_q.push_back('1);
    word_q.push_back(32'h5555_AAAA);
    wait_drained();

    // The last row and column fall outside the 2x2 blocks; two images wrap
    write_shape(2, 3, 3, 1, 2);
    push_words(18);
    wait_drained();

    // Largest shape, then zero and all-ones register values
    write_shape(MAX_BATCH, DIM_MAX, DIM_MAX, DIM_MAX, MAX_BLOCK);
    push_words(40);
    wait_drained();
    write_shape('0, '0, '0, '0, '0);
    push_words(8);
    wait_drained();
    write_shape('1, '1, '1, '1, '1);
    push_words(8);
    wait_drained();
    // Walk the batch counter through its full range and wrap
    write_shape(MAX_BATCH, 1, 1, 1, 1);
    push_words(2 * MAX_BATCH + 2);
    wait_drained();

    run_phase(10, 68, 470);
    run_phase(68, 10, 470);
    run_phase(0, 0, 470);
    wait_drained();

    $display("checked %0d output words (%0d in range, %0d last) across %0d register writes",
             n_checked, n_inside, n_last, n_writes);
    $display("shapes covered zero, oversize and max registers, blocks larger than the image");
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("space_to_depth_address_gen_core_tb OK");
    end else begin
      $display("space_to_depth_address_gen_core_tb NOT OK");
    end
    $finish;
  end

endmodule
